[hw/rtl/cda_pkg.sv]
// Shared types, constants and calendar functions for the date arithmetic unit.
`default_nettype none

package cda_pkg;

   localparam int YEAR_BITS_DEF  = 14;
   localparam int COUNT_BITS_DEF = 16;
   localparam int DAY_BITS       = 5;
   localparam int MONTH_BITS     = 4;
   localparam int DIFF_BITS      = 23;
   localparam int STATUS_BITS    = 3;
   localparam int TYPE_BITS      = 2;

   localparam int MIN_YEAR_RESET = 1600;
   localparam int DAYS_YEAR      = 365;
   localparam int DAYS_400Y      = 146097;
   localparam int YEARS_CYCLE    = 400;

   localparam logic [MONTH_BITS-1:0] JANUARY  = MONTH_BITS'(1);
   localparam logic [MONTH_BITS-1:0] DECEMBER = MONTH_BITS'(12);
   localparam logic [DAY_BITS-1:0]   LAST_DAY = DAY_BITS'(31);

   // divisibility by 25 through the modular inverse of 25 mod 2^16
   localparam int                    LEAP_BITS   = 16;
   localparam logic [LEAP_BITS-1:0]  INV25       = 16'd23593;
   localparam logic [LEAP_BITS-1:0]  DIV25_LIMIT = 16'd2621;

   typedef enum logic [TYPE_BITS-1:0] {
      MODE_CHECK = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_SUB   = 2'd2,
      MODE_DIFF  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_YEAR  = 3'd1,
      ST_BAD_MONTH = 3'd2,
      ST_BAD_DAY   = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_CHECK1,
      CS_CHECK2,
      CS_RUN,
      CS_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic check;
      logic swap;
      logic step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic       leap_ok;
      status_type check_code;
      logic       later;
      logic       step_last;
      mode_type   mode;
   } dp_status_type;

   function automatic logic is_leap(input logic [LEAP_BITS-1:0] year);
      logic [LEAP_BITS-1:0] prod;
      logic                 div25;
      prod  = year * INV25;
      div25 = (prod <= DIV25_LIMIT);
      return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
   endfunction

   function automatic logic [DAY_BITS-1:0] month_len(input logic leap,
                                                     input logic [MONTH_BITS-1:0] month);
      logic [DAY_BITS-1:0] len;
      case (month) inside
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/cda_ctrl.sv]
// Sequencing state machine for the date arithmetic unit.
`default_nettype none

module cda_ctrl import cda_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = CS_CHECK1;
            end
         end
         CS_CHECK1: begin
            if (status.leap_ok) begin
               cmd.check = 1'b1;
               if (status.check_code != ST_OK || status.mode == MODE_CHECK) begin
                  state_in = CS_DONE;
               end else if (status.mode == MODE_DIFF) begin
                  cmd.swap = 1'b1;
                  state_in = CS_CHECK2;
               end else begin
                  state_in = CS_RUN;
               end
            end
         end
         CS_CHECK2: begin
            if (status.leap_ok) begin
               cmd.check = 1'b1;
               if (status.check_code != ST_OK) begin
                  state_in = CS_DONE;
               end else begin
                  // earlier date becomes the walking date
                  cmd.swap = status.later;
                  state_in = CS_RUN;
               end
            end
         end
         CS_RUN: begin
            if (status.leap_ok) begin
               cmd.step = 1'b1;
               if (status.step_last) begin
                  state_in = CS_DONE;
               end
            end
         end
         CS_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

[hw/rtl/cda_datapath.sv]
// Date registers, validity check, month/year stepping unit and result register.
`default_nettype none

module cda_datapath import cda_pkg::*; #(
   parameter int YEAR_BITS  = YEAR_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [YEAR_BITS-1:0]   csr_wr_data,
   input  wire dp_cmd_type             cmd,
   output dp_status_type               status,
   input  wire logic [TYPE_BITS-1:0]   req_type,
   input  wire logic [DAY_BITS-1:0]    day,
   input  wire logic [MONTH_BITS-1:0]  month,
   input  wire logic [YEAR_BITS-1:0]   year,
   input  wire logic [COUNT_BITS-1:0]  day_count,
   input  wire logic [DAY_BITS-1:0]    other_day,
   input  wire logic [MONTH_BITS-1:0]  other_month,
   input  wire logic [YEAR_BITS-1:0]   other_year,
   output logic [DAY_BITS-1:0]         out_day,
   output logic [MONTH_BITS-1:0]       out_month,
   output logic [YEAR_BITS-1:0]        out_year,
   output logic [DIFF_BITS-1:0]        day_difference,
   output logic [STATUS_BITS-1:0]      out_status
);

   localparam int ACC_A    = (COUNT_BITS > YEAR_BITS + 9) ? COUNT_BITS : YEAR_BITS + 9;
   localparam int ACC_BITS = (ACC_A > DIFF_BITS + 1) ? ACC_A : DIFF_BITS + 1;
   localparam int YX_BITS  = YEAR_BITS + 1;

   localparam logic [YEAR_BITS-1:0] YEAR_MAX     = '1;
   localparam logic [YEAR_BITS-1:0] YEAR_ONE     = YEAR_BITS'(1);
   localparam logic [YEAR_BITS-1:0] YEAR_400     = YEAR_BITS'(YEARS_CYCLE);
   localparam logic [ACC_BITS-1:0]  ACC_400Y     = ACC_BITS'(DAYS_400Y);
   localparam logic [ACC_BITS-1:0]  ACC_DIFF_MAX = ACC_BITS'((1 << DIFF_BITS) - 1);

   logic [DAY_BITS-1:0]   day_ff, day_in, tday_ff, tday_in;
   logic [MONTH_BITS-1:0] month_ff, month_in, tmonth_ff, tmonth_in;
   logic [YEAR_BITS-1:0]  year_ff, year_in, tyear_ff, tyear_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   mode_type              mode_ff, mode_in;
   status_type            status_ff, status_in;
   logic                  leap_ff, leap_in;
   logic                  leap_ok_ff, leap_ok_in;
   logic [YEAR_BITS-1:0]  min_year_ff, min_year_in;

   logic [DAY_BITS-1:0]    rsp_day_ff, rsp_day_in;
   logic [MONTH_BITS-1:0]  rsp_month_ff, rsp_month_in;
   logic [YEAR_BITS-1:0]   rsp_year_ff, rsp_year_in;
   logic [DIFF_BITS-1:0]   rsp_diff_ff, rsp_diff_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic [DAY_BITS-1:0]   mlen, mlen_prev, to_end, to_next;
   logic [ACC_BITS-1:0]   ylen;
   logic [YX_BITS-1:0]    year_up400, year_lim400;
   logic                  jan1, dec31;
   status_type            check_code;
   logic                  later;

   logic [DAY_BITS-1:0]   step_day;
   logic [MONTH_BITS-1:0] step_month;
   logic [YEAR_BITS-1:0]  step_year;
   logic [ACC_BITS-1:0]   step_acc;
   logic                  step_last, step_ovf, year_kick;
   logic                  result_ok;

   assign mlen        = month_len(leap_ff, month_ff);
   assign mlen_prev   = month_len(leap_ff, month_ff - JANUARY);
   assign to_end      = mlen - day_ff;
   assign to_next     = to_end + DAY_BITS'(1);
   assign ylen        = ACC_BITS'(DAYS_YEAR) + ACC_BITS'(leap_ff);
   assign year_up400  = {1'b0, year_ff} + YX_BITS'(YEARS_CYCLE);
   assign year_lim400 = {1'b0, min_year_ff} + YX_BITS'(YEARS_CYCLE);
   assign jan1        = (month_ff == JANUARY) && (day_ff == DAY_BITS'(1));
   assign dec31       = (month_ff == DECEMBER) && (day_ff == LAST_DAY);
   assign later       = {year_ff, month_ff, day_ff} > {tyear_ff, tmonth_ff, tday_ff};

   always_comb begin
      if (year_ff < min_year_ff) begin
         check_code = ST_BAD_YEAR;
      end else if (month_ff == '0 || month_ff > DECEMBER) begin
         check_code = ST_BAD_MONTH;
      end else if (day_ff == '0 || day_ff > mlen) begin
         check_code = ST_BAD_DAY;
      end else begin
         check_code = ST_OK;
      end
   end

   // one step: a 400-year cycle, a whole year, or up to one month boundary
   always_comb begin
      step_day   = day_ff;
      step_month = month_ff;
      step_year  = year_ff;
      step_acc   = acc_ff;
      step_last  = 1'b0;
      step_ovf   = 1'b0;
      year_kick  = 1'b0;
      case (mode_ff)
         MODE_ADD: begin
            if (jan1 && acc_ff >= ACC_400Y) begin
               if (year_up400[YEAR_BITS]) begin
                  step_ovf = 1'b1;
               end else begin
                  step_year = year_up400[YEAR_BITS-1:0];
                  step_acc  = acc_ff - ACC_400Y;
               end
            end else if (jan1 && acc_ff >= ylen) begin
               if (year_ff == YEAR_MAX) begin
                  step_ovf = 1'b1;
               end else begin
                  step_year = year_ff + YEAR_ONE;
                  step_acc  = acc_ff - ylen;
                  year_kick = 1'b1;
               end
            end else if (acc_ff <= ACC_BITS'(to_end)) begin
               step_day  = day_ff + acc_ff[DAY_BITS-1:0];
               step_last = 1'b1;
            end else begin
               step_acc = acc_ff - ACC_BITS'(to_next);
               step_day = DAY_BITS'(1);
               if (month_ff == DECEMBER) begin
                  if (year_ff == YEAR_MAX) begin
                     step_ovf = 1'b1;
                  end else begin
                     step_month = JANUARY;
                     step_year  = year_ff + YEAR_ONE;
                     year_kick  = 1'b1;
                  end
               end else begin
                  step_month = month_ff + JANUARY;
               end
            end
         end
         MODE_SUB: begin
            if (dec31 && acc_ff >= ACC_400Y) begin
               if ({1'b0, year_ff} < year_lim400) begin
                  step_ovf = 1'b1;
               end else begin
                  step_year = year_ff - YEAR_400;
                  step_acc  = acc_ff - ACC_400Y;
               end
            end else if (dec31 && acc_ff >= ylen) begin
               if (year_ff == min_year_ff) begin
                  step_ovf = 1'b1;
               end else begin
                  step_year = year_ff - YEAR_ONE;
                  step_acc  = acc_ff - ylen;
                  year_kick = 1'b1;
               end
            end else if (acc_ff < ACC_BITS'(day_ff)) begin
               step_day  = day_ff - acc_ff[DAY_BITS-1:0];
               step_last = 1'b1;
            end else begin
               step_acc = acc_ff - ACC_BITS'(day_ff);
               if (month_ff == JANUARY) begin
                  if (year_ff == min_year_ff) begin
                     step_ovf = 1'b1;
                  end else begin
                     step_month = DECEMBER;
                     step_day   = LAST_DAY;
                     step_year  = year_ff - YEAR_ONE;
                     year_kick  = 1'b1;
                  end
               end else begin
                  step_month = month_ff - JANUARY;
                  step_day   = mlen_prev;
               end
            end
         end
         MODE_DIFF: begin
            if (year_ff == tyear_ff && month_ff == tmonth_ff) begin
               step_acc  = acc_ff + ACC_BITS'(tday_ff - day_ff);
               step_last = 1'b1;
            end else if (jan1 && year_up400 <= {1'b0, tyear_ff}) begin
               step_year = year_up400[YEAR_BITS-1:0];
               step_acc  = acc_ff + ACC_400Y;
            end else if (jan1 && year_ff < tyear_ff) begin
               step_year = year_ff + YEAR_ONE;
               step_acc  = acc_ff + ylen;
               year_kick = 1'b1;
            end else begin
               step_acc = acc_ff + ACC_BITS'(to_next);
               step_day = DAY_BITS'(1);
               if (month_ff == DECEMBER) begin
                  step_month = JANUARY;
                  step_year  = year_ff + YEAR_ONE;
                  year_kick  = 1'b1;
               end else begin
                  step_month = month_ff + JANUARY;
               end
            end
         end
         default: step_last = 1'b1;
      endcase
      if (step_ovf) begin
         step_last = 1'b1;
      end
   end

   always_comb begin
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      tday_in   = tday_ff;
      tmonth_in = tmonth_ff;
      tyear_in  = tyear_ff;
      acc_in    = acc_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      if (cmd.load) begin
         day_in    = day;
         month_in  = month;
         year_in   = year;
         tday_in   = other_day;
         tmonth_in = other_month;
         tyear_in  = other_year;
         mode_in   = mode_type'(req_type);
         acc_in    = (mode_type'(req_type) == MODE_DIFF) ? '0 : ACC_BITS'(day_count);
      end else if (cmd.swap) begin
         day_in    = tday_ff;
         month_in  = tmonth_ff;
         year_in   = tyear_ff;
         tday_in   = day_ff;
         tmonth_in = month_ff;
         tyear_in  = year_ff;
      end else if (cmd.step) begin
         day_in   = step_day;
         month_in = step_month;
         year_in  = step_year;
         acc_in   = step_acc;
      end
      if (cmd.check) begin
         status_in = check_code;
      end
      if (cmd.step && step_ovf) begin
         status_in = ST_OVERFLOW;
      end
   end

   // leap flag is registered from the year and so trails it; a 400-year jump keeps it
   assign leap_in     = is_leap(LEAP_BITS'(year_ff));
   assign leap_ok_in  = !(cmd.load || cmd.swap || (cmd.step && year_kick));
   assign min_year_in = csr_wr_en ? csr_wr_data : min_year_ff;

   assign result_ok = (status_ff == ST_OK);

   always_comb begin
      rsp_day_in    = rsp_day_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_diff_in   = rsp_diff_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.emit) begin
         rsp_status_in = status_ff;
         rsp_day_in    = '0;
         rsp_month_in  = '0;
         rsp_year_in   = '0;
         rsp_diff_in   = '0;
         if (result_ok && mode_ff == MODE_DIFF) begin
            rsp_diff_in = (acc_ff > ACC_DIFF_MAX) ? '1 : acc_ff[DIFF_BITS-1:0];
         end else if (result_ok) begin
            rsp_day_in   = day_ff;
            rsp_month_in = month_ff;
            rsp_year_in  = year_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leap_ok_ff  <= 1'b0;
         min_year_ff <= YEAR_BITS'(MIN_YEAR_RESET);
      end else begin
         leap_ok_ff  <= leap_ok_in;
         min_year_ff <= min_year_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff        <= day_in;
      month_ff      <= month_in;
      year_ff       <= year_in;
      tday_ff       <= tday_in;
      tmonth_ff     <= tmonth_in;
      tyear_ff      <= tyear_in;
      acc_ff        <= acc_in;
      mode_ff       <= mode_in;
      status_ff     <= status_in;
      leap_ff       <= leap_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_diff_ff   <= rsp_diff_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign status.leap_ok    = leap_ok_ff;
   assign status.check_code = check_code;
   assign status.later      = later;
   assign status.step_last  = step_last;
   assign status.mode       = mode_ff;

   assign out_day        = rsp_day_ff;
   assign out_month      = rsp_month_ff;
   assign out_year       = rsp_year_ff;
   assign day_difference = rsp_diff_ff;
   assign out_status     = rsp_status_ff;

endmodule

`default_nettype wire

[hw/rtl/calendar_date_arithmetic.sv]
// Top level of the Gregorian date unit: stream ports, controller and datapath.
//
// Requests arrive on the req_ stream: req_tuser selects the operation (check a date,
// add days, subtract days, day distance between two dates), req_tdata carries both
// dates and the day count. Each request gives exactly one transfer on the rsp_
// stream with the result date or distance in rsp_tdata and the status in rsp_tuser.
// csr_wr_en/csr_wr_data set the earliest valid year; write it only while idle.
// One request is worked on at a time. A check waits in CHECK1 for the leap-year flag,
// checks the date and emits from DONE into the output register that drives rsp_tvalid.
// Add, subtract and distance walk the calendar one step per cycle while the leap-year
// flag is fresh: a whole 400-year cycle, a whole year, or up to the next month
// boundary; each step that moves the year by one waits for the flag to be refreshed.
// The result sits in an output register, so a new request is taken while the
// previous result waits; a stalled receiver holds the next result in the controller
// until the register frees. Reset clears the controller and sets the earliest
// valid year to 1600; no result is pending after reset.
`default_nettype none

module calendar_date_arithmetic import cda_pkg::*; #(
   parameter int YEAR_BITS  = YEAR_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [YEAR_BITS-1:0]   csr_wr_data,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // day, month, year, day_count, other_day, other_month, other_year, zero pad
   input  wire logic [((2*YEAR_BITS+COUNT_BITS+2*(DAY_BITS+MONTH_BITS)+7)/8)*8-1:0]
                                       req_tdata,
   // req_type
   input  wire logic [TYPE_BITS-1:0]   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // out_day, out_month, out_year, day_difference, zero pad
   output logic [((YEAR_BITS+DAY_BITS+MONTH_BITS+DIFF_BITS+7)/8)*8-1:0]
                                       rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0]      rsp_tuser
);

   localparam int OFF_MONTH  = DAY_BITS;
   localparam int OFF_YEAR   = OFF_MONTH + MONTH_BITS;
   localparam int OFF_COUNT  = OFF_YEAR + YEAR_BITS;
   localparam int OFF_ODAY   = OFF_COUNT + COUNT_BITS;
   localparam int OFF_OMONTH = OFF_ODAY + DAY_BITS;
   localparam int OFF_OYEAR  = OFF_OMONTH + MONTH_BITS;
   localparam int RSP_BITS   = ((YEAR_BITS + DAY_BITS + MONTH_BITS + DIFF_BITS + 7) / 8) * 8;

   dp_cmd_type            dp_cmd;
   dp_status_type         dp_status;
   logic [DAY_BITS-1:0]   out_day;
   logic [MONTH_BITS-1:0] out_month;
   logic [YEAR_BITS-1:0]  out_year;
   logic [DIFF_BITS-1:0]  day_difference;
   logic [STATUS_BITS-1:0] out_status;

   cda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   cda_datapath #(
      .YEAR_BITS  (YEAR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .req_type       (req_tuser),
      .day            (req_tdata[DAY_BITS-1:0]),
      .month          (req_tdata[OFF_MONTH +: MONTH_BITS]),
      .year           (req_tdata[OFF_YEAR +: YEAR_BITS]),
      .day_count      (req_tdata[OFF_COUNT +: COUNT_BITS]),
      .other_day      (req_tdata[OFF_ODAY +: DAY_BITS]),
      .other_month    (req_tdata[OFF_OMONTH +: MONTH_BITS]),
      .other_year     (req_tdata[OFF_OYEAR +: YEAR_BITS]),
      .out_day        (out_day),
      .out_month      (out_month),
      .out_year       (out_year),
      .day_difference (day_difference),
      .out_status     (out_status)
   );

   assign rsp_tdata = RSP_BITS'({day_difference, out_year, out_month, out_day});
   assign rsp_tuser = out_status;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_status != ST_OK |-> rsp_tdata == '0)
      else $error("failed result carries non-zero payload");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_status == ST_OK && out_month != '0
      |-> day_difference == '0 && out_day != '0 && out_month <= DECEMBER)
      else $error("result date out of calendar range");

   a_leap_fresh: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.step || dp_cmd.check |-> dp_status.leap_ok)
      else $error("calendar step on a stale leap-year flag");

endmodule

`default_nettype wire
